// File: sv/positional_ordered_list_defines.svh
// Assertion macros shared by the positional ordered list RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef POSITIONAL_ORDERED_LIST_DEFINES_SVH
`define POSITIONAL_ORDERED_LIST_DEFINES_SVH

// Generic clocked assertion with an explicit clock and active-low reset.
`define POL_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the block clock clk_i and reset rst_ni.
`define POL_ASSERT(label, prop, msg) \
  `POL_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// File: sv/pol_pkg.sv
// Shared codes and types of the positional ordered list.
// No dependencies; used by pol_cell and positional_ordered_list.
package pol_pkg;

  // Command codes carried by mode_i.
  localparam logic [2:0] ModeInsPos  = 3'd0;
  localparam logic [2:0] ModeInsHead = 3'd1;
  localparam logic [2:0] ModeInsTail = 3'd2;
  localparam logic [2:0] ModeDelPos  = 3'd3;
  localparam logic [2:0] ModeDelHead = 3'd4;
  localparam logic [2:0] ModeDelTail = 3'd5;
  localparam logic [2:0] ModeClear   = 3'd6;
  localparam logic [2:0] ModeReadOut = 3'd7;

  // Result status codes.
  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusInvalid = 2'd1;
  localparam logic [1:0] StatusEmpty   = 2'd2;
  localparam logic [1:0] StatusFull    = 2'd3;

  // Per-cycle action of the cell chain.
  typedef enum logic [1:0] {
    CellHold   = 2'd0,
    CellInsert = 2'd1,
    CellDelete = 2'd2,
    CellRotate = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e    op;
    logic [31:0] value;
  } cell_ctl_t;

endpackage

// File: sv/pol_cell.sv
// One storage cell of the list chain: holds one element and trades it with neighbors.
// Depends on pol_pkg.
module pol_cell #(
  parameter int IDX_W      = 6,
  parameter int CELL_INDEX = 0
) (
  input  logic                clk_i,
  input  pol_pkg::cell_ctl_t  ctl_i,
  input  logic [IDX_W-1:0]    idx_i,
  input  logic [31:0]         left_i,
  input  logic [31:0]         right_i,
  input  logic [31:0]         wrap_i,
  output logic [31:0]         word_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_INDEX);

  logic [31:0] word_d, word_q;

  always_comb begin
    word_d = word_q;
    case (ctl_i.op)
      pol_pkg::CellInsert: begin
        if (MyIdx > idx_i) begin
          word_d = left_i;
        end else if (MyIdx == idx_i) begin
          word_d = ctl_i.value;
        end
      end
      pol_pkg::CellDelete: begin
        if (MyIdx >= idx_i) begin
          word_d = right_i;
        end
      end
      // During read-out the occupied part of the chain turns around by one
      // place per cycle; the head re-enters at the tail slot.
      pol_pkg::CellRotate: begin
        if (MyIdx == idx_i) begin
          word_d = wrap_i;
        end else if (MyIdx < idx_i) begin
          word_d = right_i;
        end
      end
      default: begin
        word_d = word_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

// File: sv/positional_ordered_list.sv
// Top level of the positional ordered list: command decode, count and a chain of cells.
// Depends on pol_pkg, pol_cell and positional_ordered_list_defines.svh.
//
// Channel   Direction  Handshake               Payload
// command   in         start, busy             mode_i, position_i, value_i
// result    out        valid_o (one cycle)     status_o, element_count_o, element_o,
//                                              has_element_o, is_last_o
//
// Every command except a non-empty read-out shows its result in the cycle after the request
// edge and busy stays low, so commands may follow each other in every cycle.
// A read-out of N elements keeps busy high while the chain rotates, one result per cycle,
// set by the rotation of the cell chain through its head cell; the next request is taken
// once busy falls again. An empty read-out leaves busy low and returns one result.
// Reset clears the count and control; element contents stay undefined until written.
// The receiver cannot stall: each result is valid for exactly one cycle.
`include "positional_ordered_list_defines.svh"

module positional_ordered_list #(
  parameter int CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  mode_i,
  input  logic [6:0]  position_i,
  input  logic [31:0] value_i,
  output logic        valid_o,
  output logic [1:0]  status_o,
  output logic [6:0]  element_count_o,
  output logic [31:0] element_o,
  output logic        has_element_o,
  output logic        is_last_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int PW = ((CW > 7) ? CW : 7) + 1;

  localparam logic StIdle = 1'b0;
  localparam logic StRead = 1'b1;

  logic               state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      rd_cnt_q, rd_cnt_d;
  logic               accept;
  logic               reading;
  logic               rd_start;
  logic               full, empty;
  logic [PW-1:0]      pos_ext, cnt_ext;
  logic [1:0]         st;
  logic [IW-1:0]      idx;
  pol_pkg::cell_ctl_t ctl;
  logic [31:0]        words [CAPACITY];

  logic               valid_q;
  logic [1:0]         status_q;
  logic [CW-1:0]      res_count_q;
  logic [31:0]        element_q;
  logic               has_element_q;
  logic               is_last_q;
  logic               rd_last;

  assign busy    = (state_q == StRead);
  assign accept  = start && !busy;
  assign reading = (state_q == StRead);
  assign full    = (count_q == CW'(CAPACITY));
  assign empty   = (count_q == '0);
  assign pos_ext = PW'(position_i);
  assign cnt_ext = PW'(count_q);
  assign rd_last = (rd_cnt_q == count_q - CW'(1));

  always_comb begin
    st        = pol_pkg::StatusOk;
    ctl.op    = pol_pkg::CellHold;
    ctl.value = value_i;
    idx       = '0;
    count_d   = count_q;
    rd_start  = 1'b0;
    state_d   = state_q;
    rd_cnt_d  = rd_cnt_q;
    if (accept) begin
      case (mode_i)
        pol_pkg::ModeInsPos: begin
          if (pos_ext == '0 || pos_ext > cnt_ext + PW'(1)) begin
            st = pol_pkg::StatusInvalid;
          end else if (full) begin
            st = pol_pkg::StatusFull;
          end else begin
            ctl.op  = pol_pkg::CellInsert;
            idx     = IW'(pos_ext - PW'(1));
            count_d = count_q + CW'(1);
          end
        end
        pol_pkg::ModeInsHead: begin
          if (full) begin
            st = pol_pkg::StatusFull;
          end else begin
            ctl.op  = pol_pkg::CellInsert;
            count_d = count_q + CW'(1);
          end
        end
        pol_pkg::ModeInsTail: begin
          if (full) begin
            st = pol_pkg::StatusFull;
          end else begin
            ctl.op  = pol_pkg::CellInsert;
            idx     = IW'(count_q);
            count_d = count_q + CW'(1);
          end
        end
        pol_pkg::ModeDelPos: begin
          if (pos_ext == '0 || pos_ext > cnt_ext) begin
            st = pol_pkg::StatusInvalid;
          end else begin
            ctl.op  = pol_pkg::CellDelete;
            idx     = IW'(pos_ext - PW'(1));
            count_d = count_q - CW'(1);
          end
        end
        pol_pkg::ModeDelHead: begin
          if (empty) begin
            st = pol_pkg::StatusEmpty;
          end else begin
            ctl.op  = pol_pkg::CellDelete;
            count_d = count_q - CW'(1);
          end
        end
        pol_pkg::ModeDelTail: begin
          // The tail word is simply dropped by shrinking the count.
          if (empty) begin
            st = pol_pkg::StatusEmpty;
          end else begin
            count_d = count_q - CW'(1);
          end
        end
        pol_pkg::ModeClear: begin
          count_d = '0;
        end
        default: begin
          if (empty) begin
            st = pol_pkg::StatusEmpty;
          end else begin
            rd_start = 1'b1;
            state_d  = StRead;
            rd_cnt_d = '0;
          end
        end
      endcase
    end else if (reading) begin
      ctl.op   = pol_pkg::CellRotate;
      idx      = IW'(count_q - CW'(1));
      rd_cnt_d = rd_cnt_q + CW'(1);
      if (rd_last) begin
        state_d = StIdle;
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [31:0] left_w, right_w;
    if (g == 0) begin : g_head
      assign left_w = value_i;
    end else begin : g_mid_l
      assign left_w = words[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = words[g+1];
    end
    pol_cell #(
      .IDX_W      (IW),
      .CELL_INDEX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .idx_i   (idx),
      .left_i  (left_w),
      .right_i (right_w),
      .wrap_i  (words[0]),
      .word_o  (words[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      count_q  <= '0;
      rd_cnt_q <= '0;
      valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_cnt_q <= rd_cnt_d;
      valid_q  <= (accept && !rd_start) || reading;
    end
  end

  always_ff @(posedge clk_i) begin
    if (reading) begin
      status_q      <= pol_pkg::StatusOk;
      res_count_q   <= count_q;
      element_q     <= words[0];
      has_element_q <= 1'b1;
      is_last_q     <= rd_last;
    end else begin
      status_q      <= st;
      res_count_q   <= count_d;
      element_q     <= '0;
      has_element_q <= 1'b0;
      is_last_q     <= 1'b1;
    end
  end

  assign valid_o         = valid_q;
  assign status_o        = status_q;
  assign element_count_o = 7'(res_count_q);
  assign element_o       = element_q;
  assign has_element_o   = has_element_q;
  assign is_last_o       = is_last_q;

  `POL_ASSERT(a_count_bounded, count_q <= CW'(CAPACITY), "element count above capacity")
  `POL_ASSERT(a_read_starts,
              (start && !busy && mode_i == pol_pkg::ModeReadOut && count_q != '0) |=> busy,
              "read-out did not start")
  `POL_ASSERT(a_rd_cnt_range, reading |-> (rd_cnt_q < count_q),
              "read counter past element count")
  `POL_ASSERT(a_last_frees, (valid_o && has_element_o && is_last_o) |-> !busy,
              "busy after last read result")
  `POL_ASSERT(a_element_ok, (valid_o && has_element_o) |-> (status_o == pol_pkg::StatusOk),
              "read result with bad status")

endmodule

// File: tb/pol_list_checker.sv
`timescale 1ns / 100ps
// Checker for the positional ordered list: watches the request and result ports,
// predicts every result from its own copy of the list and compares. Depends on pol_pkg.
module pol_list_checker #(
  parameter int CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  mode_i,
  input  logic [6:0]  position_i,
  input  logic [31:0] value_i,
  input  logic        valid_o,
  input  logic [1:0]  status_o,
  input  logic [6:0]  element_count_o,
  input  logic [31:0] element_o,
  input  logic        has_element_o,
  input  logic        is_last_o,
  output int          mismatches,
  output int          awaiting,
  output int          list_len,
  output int          results_checked,
  output int          full_hits
);

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  count;
    logic [31:0] element;
    logic        has;
    logic        last;
  } list_result_t;

  logic [31:0]  contents[$];
  list_result_t pending_results[$];
  int           fault_total;
  int           checked_total;
  int           full_total;

  function automatic void push_result(logic [1:0] st, logic [31:0] elem, logic has,
                                      logic last);
    list_result_t r;
    r.status  = st;
    r.count   = 7'(contents.size());
    r.element = elem;
    r.has     = has;
    r.last    = last;
    pending_results.push_back(r);
    if (st == pol_pkg::StatusFull) full_total++;
  endfunction

  // Applies one accepted request to the shadow list and queues what it should produce.
  function automatic void apply_command(logic [2:0] mode, logic [6:0] pos, logic [31:0] val);
    int         n;
    logic [1:0] st;
    n  = contents.size();
    st = pol_pkg::StatusOk;
    case (mode)
      pol_pkg::ModeInsPos: begin
        if (pos < 1 || pos > n + 1) st = pol_pkg::StatusInvalid;
        else if (n >= CAPACITY) st = pol_pkg::StatusFull;
        else contents.insert(pos - 1, val);
      end
      pol_pkg::ModeInsHead: begin
        if (n >= CAPACITY) st = pol_pkg::StatusFull;
        else contents.push_front(val);
      end
      pol_pkg::ModeInsTail: begin
        if (n >= CAPACITY) st = pol_pkg::StatusFull;
        else contents.push_back(val);
      end
      pol_pkg::ModeDelPos: begin
        if (pos < 1 || pos > n) st = pol_pkg::StatusInvalid;
        else contents.delete(pos - 1);
      end
      pol_pkg::ModeDelHead: begin
        if (n == 0) st = pol_pkg::StatusEmpty;
        else void'(contents.pop_front());
      end
      pol_pkg::ModeDelTail: begin
        if (n == 0) st = pol_pkg::StatusEmpty;
        else void'(contents.pop_back());
      end
      pol_pkg::ModeClear: contents.delete();
      default: begin
        if (n == 0) push_result(pol_pkg::StatusEmpty, 32'd0, 1'b0, 1'b1);
        for (int i = 0; i < n; i++)
          push_result(pol_pkg::StatusOk, contents[i], 1'b1, i == n - 1);
        return;
      end
    endcase
    push_result(st, 32'd0, 1'b0, 1'b1);
  endfunction

  function automatic void report_fault(string why, list_result_t want, list_result_t got);
    fault_total++;
    if (fault_total <= 10) begin
      $display("[%0t] %s: expected st=%0d cnt=%0d elem=%h has=%b last=%b",
               $time, why, want.status, want.count, want.element, want.has, want.last);
      $display("    got st=%0d cnt=%0d elem=%h has=%b last=%b",
               got.status, got.count, got.element, got.has, got.last);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t got;
    list_result_t want;
    if (!rst_ni) begin
      contents.delete();
      pending_results.delete();
      fault_total   = 0;
      checked_total = 0;
      full_total    = 0;
    end else begin
      // Results on the ports now belong to earlier requests, so check before predicting.
      if (valid_o) begin
        got = {status_o, element_count_o, element_o, has_element_o, is_last_o};
        checked_total++;
        if (pending_results.size() == 0) begin
          report_fault("result with nothing pending", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status || got.count !== want.count ||
              got.element !== want.element || got.has !== want.has ||
              got.last !== want.last)
            report_fault("result mismatch", want, got);
        end
      end
      if (start && !busy) apply_command(mode_i, position_i, value_i);
    end
    mismatches      <= fault_total;
    awaiting        <= pending_results.size();
    list_len        <= contents.size();
    results_checked <= checked_total;
    full_hits       <= full_total;
  end

endmodule

// File: tb/tb_positional_ordered_list.sv
`timescale 1ns / 100ps
// Top of the positional ordered list testbench: clock, reset, request stimulus and verdict.
// Depends on pol_pkg, positional_ordered_list and pol_list_checker.
module tb_positional_ordered_list;

  localparam int CAPACITY   = 64;
  localparam int CYCLE_CAP  = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [2:0]  mode_i;
  logic [6:0]  position_i;
  logic [31:0] value_i;
  logic        valid_o;
  logic [1:0]  status_o;
  logic [6:0]  element_count_o;
  logic [31:0] element_o;
  logic        has_element_o;
  logic        is_last_o;

  int mismatches;
  int awaiting;
  int list_len;
  int results_checked;
  int full_hits;
  int cycle_count = 0;
  int requests_sent;
  int burst_left;

  positional_ordered_list #(.CAPACITY(CAPACITY)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .mode_i          (mode_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .valid_o         (valid_o),
    .status_o        (status_o),
    .element_count_o (element_count_o),
    .element_o       (element_o),
    .has_element_o   (has_element_o),
    .is_last_o       (is_last_o)
  );

  pol_list_checker #(.CAPACITY(CAPACITY)) checker_inst (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .mode_i          (mode_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .valid_o         (valid_o),
    .status_o        (status_o),
    .element_count_o (element_count_o),
    .element_o       (element_o),
    .has_element_o   (has_element_o),
    .is_last_o       (is_last_o),
    .mismatches      (mismatches),
    .awaiting        (awaiting),
    .list_len        (list_len),
    .results_checked (results_checked),
    .full_hits       (full_hits)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Holds the request until the block takes it at a rising edge with busy low.
  task automatic send_request(logic [2:0] mode, logic [6:0] pos, logic [31:0] val);
    @(negedge clk_i);
    start      <= 1'b1;
    mode_i     <= mode;
    position_i <= pos;
    value_i    <= val;
    do @(posedge clk_i); while (busy);
    requests_sent++;
  endtask

  task automatic idle_cycles(int n);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // Bursts of back-to-back requests separated by random gaps, with an occasional long run.
  task automatic pace();
    if (burst_left == 0) begin
      idle_cycles($urandom_range(1, 6));
      burst_left = ($urandom_range(7) == 0) ? 40 : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(11))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [6:0] pick_position(logic [2:0] mode);
    int top_pos;
    top_pos = (mode == pol_pkg::ModeInsPos) ? list_len + 1 : list_len;
    if (top_pos < 1) top_pos = 1;
    case ($urandom_range(9))
      0: return 7'd0;
      1: return 7'($urandom_range(0, 127));
      2: return 7'(list_len + 1);
      3: return 7'(list_len + 2);
      default: return 7'($urandom_range(1, top_pos));
    endcase
  endfunction

  // Phase 0 grows the list towards full, phase 1 mixes everything, phase 2 drains it.
  function automatic logic [2:0] pick_mode(int phase);
    int r;
    r = $urandom_range(99);
    case (phase)
      0: begin
        if (r < 35) return pol_pkg::ModeInsPos;
        if (r < 60) return pol_pkg::ModeInsHead;
        if (r < 85) return pol_pkg::ModeInsTail;
        if (r < 90) return pol_pkg::ModeDelPos;
        if (r < 93) return pol_pkg::ModeDelHead;
        if (r < 95) return pol_pkg::ModeDelTail;
        return pol_pkg::ModeReadOut;
      end
      1: begin
        if (r < 2) return pol_pkg::ModeClear;
        if (r < 10) return pol_pkg::ModeReadOut;
        return 3'($urandom_range(0, 5));
      end
      default: begin
        if (r < 30) return pol_pkg::ModeDelPos;
        if (r < 55) return pol_pkg::ModeDelHead;
        if (r < 80) return pol_pkg::ModeDelTail;
        if (r < 92) return 3'($urandom_range(0, 2));
        return pol_pkg::ModeReadOut;
      end
    endcase
  endfunction

  initial begin
    logic [2:0] mode;
    requests_sent = 0;
    burst_left    = 0;
    rst_ni        = 1'b0;
    start         = 1'b0;
    mode_i        = pol_pkg::ModeInsPos;
    position_i    = 7'd0;
    value_i       = 32'd0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty-list corner cases first, then each command on a small list.
    send_request(pol_pkg::ModeReadOut, 7'd0, 32'd0);
    send_request(pol_pkg::ModeDelHead, 7'd0, 32'd0);
    send_request(pol_pkg::ModeDelTail, 7'd0, 32'd0);
    send_request(pol_pkg::ModeDelPos, 7'd1, 32'd0);
    send_request(pol_pkg::ModeDelPos, 7'd0, 32'd0);
    send_request(pol_pkg::ModeInsPos, 7'd0, 32'h1234_5678);
    send_request(pol_pkg::ModeInsPos, 7'd2, 32'h1234_5678);
    send_request(pol_pkg::ModeInsPos, 7'd1, 32'h7fff_ffff);
    send_request(pol_pkg::ModeInsHead, 7'd127, 32'h8000_0000);
    send_request(pol_pkg::ModeInsTail, 7'd0, 32'hffff_ffff);
    send_request(pol_pkg::ModeInsPos, 7'd4, 32'h0000_0000);
    send_request(pol_pkg::ModeInsPos, 7'd2, 32'h5555_5555);
    send_request(pol_pkg::ModeInsPos, 7'd7, 32'haaaa_aaaa);
    send_request(pol_pkg::ModeReadOut, 7'd0, 32'd0);
    send_request(pol_pkg::ModeDelPos, 7'd6, 32'd0);
    send_request(pol_pkg::ModeDelPos, 7'd127, 32'd0);
    send_request(pol_pkg::ModeDelPos, 7'd3, 32'd0);
    send_request(pol_pkg::ModeDelHead, 7'd0, 32'd0);
    send_request(pol_pkg::ModeDelTail, 7'd0, 32'd0);
    send_request(pol_pkg::ModeReadOut, 7'd0, 32'd0);
    idle_cycles(3);
    send_request(pol_pkg::ModeClear, 7'd0, 32'd0);
    send_request(pol_pkg::ModeReadOut, 7'd0, 32'd0);
    send_request(pol_pkg::ModeClear, 7'd0, 32'd0);

    for (int round = 0; round < 3; round++) begin
      for (int phase = 0; phase < 3; phase++) begin
        for (int k = 0; k < ((phase == 0) ? 100 : (phase == 1) ? 35 : 22); k++) begin
          mode = pick_mode(phase);
          send_request(mode, pick_position(mode), pick_value());
          pace();
        end
      end
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (awaiting != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Drove %0d requests over %0d cycles; %0d results compared.",
             requests_sent, cycle_count, results_checked);
    $display("The list reported full %0d times; %0d mismatches, %0d results outstanding.",
             full_hits, mismatches, awaiting);
    if (mismatches == 0 && awaiting == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/pol_pkg.sv
sv/pol_cell.sv
sv/positional_ordered_list.sv
tb/pol_list_checker.sv
tb/tb_positional_ordered_list.sv
